/* sv/hdu_pkg.sv */
// Shared constants, types and the arctangent table for the haversine distance unit.
// No dependencies; every other file imports this package.
`default_nettype none

package hdu_pkg;

	// fixed-point layout
	localparam int ANGLE_FRAC_BITS = 20;
	localparam int CORDIC_STAGES = 24;
	localparam int SQRT_STAGES = 31;
	localparam int DW = 34;

	// degrees to binary turns: round(2^40 / 360)
	localparam logic [31:0] TURN_MUL = 32'd3054198966;
	localparam logic signed [DW-1:0] INV_GAIN = 34'sd652032874;
	localparam logic [30:0] PI_Q29 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30 = 31'h40000000;
	localparam logic [15:0] RADIUS_RESET = 16'd6371;
	localparam logic [25:0] OUT_MAX = 26'h3FFFFFF;

	// register map
	typedef enum logic {
		REG_RADIUS = 1'b0
	} reg_idx_t;

	// one point pair in binary turns, as handed from front to back
	typedef struct packed {
		logic [31:0] lat1;
		logic [31:0] lat2;
		logic [31:0] dlat_half;
		logic [31:0] dlon_half;
	} item_t;

	// atan(2^-i) in turns, 2^32 per turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2F9;
			15: r = 32'h0000517C;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A2F;
			19: r = 32'h00000517;
			20: r = 32'h0000028B;
			21: r = 32'h00000145;
			22: r = 32'h000000A2;
			23: r = 32'h00000051;
			24: r = 32'h00000028;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000002;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/haversine_distance_unit.sv */
// Top level of the haversine great-circle distance unit: ports, radius register, front and back.
// Depends on hdu_pkg, hdu_front, hdu_back.
//
//   channel   handshake            payload
//   input     push / full          first/second latitude, first/second longitude
//   result    empty / pop          great_circle_distance
//   config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// One point pair per cycle while results are claimed; a result passes through the front queue,
// the rotation CORDIC, square-root and vectoring CORDIC pipelines, the scaling registers and dist_q.
// Reset clears the queue, the stage valid bits and loads the radius with 6371 km.
// A result left unclaimed stalls the whole back pipeline; the front queue of two
// entries keeps taking transactions until it fills.
`default_nettype none

module haversine_distance_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [27:0] first_latitude,
	input  wire logic signed [28:0] first_longitude,
	input  wire logic signed [27:0] second_latitude,
	input  wire logic signed [28:0] second_longitude,
	output logic                    empty,
	input  wire logic               pop,
	output logic [25:0]             great_circle_distance,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import hdu_pkg::*;

	logic [15:0] radius_q;
	logic        q_empty, deq;
	item_t       item;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[2]);

	// write the radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && (idx == REG_RADIUS)) begin
			radius_q <= pwdata[15:0];
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_RADIUS: prdata = {16'b0, radius_q};
			default: prdata = '0;
		endcase
	end

	hdu_front u_front (
		.clk, .arst_n, .push, .full,
		.first_latitude, .first_longitude, .second_latitude, .second_longitude,
		.deq, .q_empty, .item
	);

	hdu_back u_back (
		.clk, .arst_n, .q_empty, .item, .deq,
		.radius(radius_q), .empty, .pop, .great_circle_distance
	);

endmodule

`default_nettype wire

/* sv/hdu_front.sv */
// Front end: converts degrees to turns, forms half differences, buffers in a two-entry queue.
// Depends on hdu_pkg.
`default_nettype none

module hdu_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic signed [27:0]  first_latitude,
	input  wire logic signed [28:0]  first_longitude,
	input  wire logic signed [27:0]  second_latitude,
	input  wire logic signed [28:0]  second_longitude,
	input  wire logic                deq,
	output logic                     q_empty,
	output hdu_pkg::item_t           item
);
	import hdu_pkg::*;

	localparam int SH = ANGLE_FRAC_BITS + 8;

	// floor(deg * TURN_MUL / 2^SH) mod 2^32
	function automatic logic [31:0] to_turn(input logic signed [28:0] deg);
		logic signed [SH+31:0] p;
		p = deg * $signed({1'b0, TURN_MUL});
		return p[SH+31:SH];
	endfunction

	logic [31:0] la1, lo1, la2, lo2, dlat, dlon;
	item_t       wr_item;
	item_t       mem_q [0:1];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        do_wr, do_rd;

	// convert the incoming transaction
	always_comb begin
		la1 = to_turn({first_latitude[27], first_latitude});
		lo1 = to_turn(first_longitude);
		la2 = to_turn({second_latitude[27], second_latitude});
		lo2 = to_turn(second_longitude);
		dlat = la2 - la1;
		dlon = lo2 - lo1;
		wr_item.lat1 = la1;
		wr_item.lat2 = la2;
		wr_item.dlat_half = {1'b0, dlat[31:1]};
		wr_item.dlon_half = {1'b0, dlon[31:1]};
	end

	assign full = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign do_wr = push && !full;
	assign do_rd = deq && !q_empty;
	assign item = mem_q[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wr_q <= ~wr_q;
			if (do_rd) rd_q <= ~rd_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

/* sv/hdu_cordic_rot.sv */
// Pipelined rotation CORDIC: sine and cosine, signed Q4.30, of a turn angle.
// Depends on hdu_pkg.
`default_nettype none

module hdu_cordic_rot (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [31:0]                  angle,
	output logic signed [hdu_pkg::DW-1:0]     cos_val,
	output logic signed [hdu_pkg::DW-1:0]     sin_val
);
	import hdu_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic signed [DW-1:0] x_s [0:N];
	logic signed [DW-1:0] y_s [0:N];
	logic signed [DW-1:0] z_s [0:N];
	logic                 flip_s [0:N];
	logic                 flip;
	logic [31:0]          folded;

	// fold the second and third quadrant by a half turn
	always_comb begin
		flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
		folded = flip ? (angle + 32'h80000000) : angle;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= INV_GAIN;
			y_s[0] <= '0;
			z_s[0] <= {{(DW-32){folded[31]}}, folded};
			flip_s[0] <= flip;
		end
	end

	// rotate toward zero residual angle
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({{(DW-32){1'b0}}, atan_turn(i)});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({{(DW-32){1'b0}}, atan_turn(i)});
				end
			end
		end
	end

	assign cos_val = flip_s[N] ? -x_s[N] : x_s[N];
	assign sin_val = flip_s[N] ? -y_s[N] : y_s[N];

endmodule

`default_nettype wire

/* sv/hdu_sqrt.sv */
// Pipelined integer square root of a * 2^30, one result bit per stage.
// Depends on hdu_pkg.
`default_nettype none

module hdu_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] value,
	output logic [30:0]      root
);
	import hdu_pkg::*;

	localparam int S = SQRT_STAGES;
	localparam int VW = 2 * S;

	logic [32:0]   rem_s  [0:S];
	logic [30:0]   root_s [0:S];
	logic [VW-1:0] data_s [0:S];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			root_s[0] <= '0;
			data_s[0] <= {1'b0, value, 30'b0};
		end
	end

	// bring down two bits, try subtracting 4r+1
	for (genvar k = 0; k < S; k++) begin : g_stage
		logic [34:0] cur, trial;
		always_comb begin
			cur = {rem_s[k], data_s[k][VW-1:VW-2]};
			trial = {2'b00, root_s[k], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				data_s[k+1] <= {data_s[k][VW-3:0], 2'b00};
				if (cur >= trial) begin
					rem_s[k+1] <= 33'(cur - trial);
					root_s[k+1] <= {root_s[k][29:0], 1'b1};
				end else begin
					rem_s[k+1] <= cur[32:0];
					root_s[k+1] <= {root_s[k][29:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[S];

endmodule

`default_nettype wire

/* sv/hdu_cordic_vec.sv */
// Pipelined vectoring CORDIC: angle of (x, y) in turns.
// Depends on hdu_pkg.
`default_nettype none

module hdu_cordic_vec (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [30:0]              x_in,
	input  wire logic [30:0]              y_in,
	output logic signed [hdu_pkg::DW-1:0] angle
);
	import hdu_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic signed [DW-1:0] x_s [0:N];
	logic signed [DW-1:0] y_s [0:N];
	logic signed [DW-1:0] z_s [0:N];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= $signed({{(DW-31){1'b0}}, x_in});
			y_s[0] <= $signed({{(DW-31){1'b0}}, y_in});
			z_s[0] <= '0;
		end
	end

	// drive y toward zero, accumulate the angle
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({{(DW-32){1'b0}}, atan_turn(i)});
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({{(DW-32){1'b0}}, atan_turn(i)});
				end
			end
		end
	end

	assign angle = z_s[N];

endmodule

`default_nettype wire

/* sv/hdu_back.sv */
// Back end: trig, haversine term, roots, central angle and scaling, with output register.
// Depends on hdu_pkg, hdu_cordic_rot, hdu_sqrt, hdu_cordic_vec.
`default_nettype none

module hdu_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire hdu_pkg::item_t item,
	output logic                deq,
	input  wire logic [15:0]    radius,
	output logic                empty,
	input  wire logic           pop,
	output logic [25:0]         great_circle_distance
);
	import hdu_pkg::*;

	localparam int LAT = 2 * CORDIC_STAGES + SQRT_STAGES + 7;

	logic                 en;
	logic                 valid_s [0:LAT-1];
	logic                 out_valid_q;
	logic [25:0]          dist_q;
	logic signed [DW-1:0] cl, sl, co, so, c1, s1, c2, s2;
	logic signed [DW-1:0] sl2_s, c12_s, so2_s;
	logic signed [2*DW-1:0] p_sl, p_c12, p_so, p_t;
	logic signed [DW:0]   asum;
	logic [30:0]          a_s, a_inv, root_a, root_b, zc;
	logic signed [DW-1:0] vz;
	logic [61:0]          prod_s;
	logic [62:0]          wsum;
	logic [31:0]          w;
	logic [47:0]          dprod_s;
	logic [48:0]          dsum;
	logic [26:0]          dfull;

	// whole pipeline moves unless a result waits unclaimed
	assign en = !out_valid_q || pop;
	assign deq = en;

	hdu_cordic_rot u_rot_dlat (.clk, .en, .angle(item.dlat_half), .cos_val(cl), .sin_val(sl));
	hdu_cordic_rot u_rot_dlon (.clk, .en, .angle(item.dlon_half), .cos_val(co), .sin_val(so));
	hdu_cordic_rot u_rot_lat1 (.clk, .en, .angle(item.lat1), .cos_val(c1), .sin_val(s1));
	hdu_cordic_rot u_rot_lat2 (.clk, .en, .angle(item.lat2), .cos_val(c2), .sin_val(s2));

	// squares and cosine product
	always_comb begin
		p_sl = sl * sl;
		p_c12 = c1 * c2;
		p_so = so * so;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sl2_s <= p_sl[DW+29:30];
			c12_s <= p_c12[DW+29:30];
			so2_s <= p_so[DW+29:30];
		end
	end

	// haversine term, clamped to [0, 1]
	always_comb begin
		p_t = c12_s * so2_s;
		asum = {sl2_s[DW-1], sl2_s} + {p_t[DW+29], p_t[DW+29:30]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (asum < 0) a_s <= '0;
			else if (asum > $signed({{(DW-30){1'b0}}, ONE_Q30})) a_s <= ONE_Q30;
			else a_s <= asum[30:0];
		end
	end

	assign a_inv = ONE_Q30 - a_s;

	hdu_sqrt u_sqrt_a (.clk, .en, .value(a_s), .root(root_a));
	hdu_sqrt u_sqrt_b (.clk, .en, .value(a_inv), .root(root_b));

	hdu_cordic_vec u_vec (.clk, .en, .x_in(root_b), .y_in(root_a), .angle(vz));

	// clamp central angle, scale by pi
	always_comb begin
		if (vz < 0) zc = '0;
		else if (vz > $signed({{(DW-31){1'b0}}, ONE_Q30})) zc = ONE_Q30;
		else zc = vz[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= zc * PI_Q29;
		end
	end

	// round to radians Q30, scale by radius
	always_comb begin
		wsum = {1'b0, prod_s} + 63'(64'd1 << 28);
		w = wsum[60:29];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s <= w * radius;
		end
	end

	// round and saturate
	always_comb begin
		dsum = {1'b0, dprod_s} + 49'(64'd1 << 21);
		dfull = dsum[48:22];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= dfull[26] ? OUT_MAX : dfull[25:0];
		end
	end

	// track valid transactions through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LAT; j++) valid_s[j] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s[0] <= !q_empty;
			for (int j = 1; j < LAT; j++) valid_s[j] <= valid_s[j-1];
			out_valid_q <= valid_s[LAT-1];
		end
	end

	assign empty = !out_valid_q;
	assign great_circle_distance = dist_q;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for haversine_distance_unit: random and directed point pairs, radius sweeps.
// Depends on hdu_pkg and the unit's RTL; predicts distances with its own fixed-point model.
`timescale 1ns / 1ps

module testbench;
	import hdu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [27:0] first_latitude = '0;
	logic signed [28:0] first_longitude = '0;
	logic signed [27:0] second_latitude = '0;
	logic signed [28:0] second_longitude = '0;
	logic empty;
	logic pop = 1'b0;
	logic [25:0] great_circle_distance;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	haversine_distance_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.first_latitude(first_latitude), .first_longitude(first_longitude),
		.second_latitude(second_latitude), .second_longitude(second_longitude),
		.empty(empty), .pop(pop), .great_circle_distance(great_circle_distance),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef struct packed {
		logic [27:0] lat1;
		logic [28:0] lon1;
		logic [27:0] lat2;
		logic [28:0] lon2;
	} point_pair_t;

	localparam int LATENCY = 2 * CORDIC_STAGES + SQRT_STAGES + 9;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PP_W = $bits(point_pair_t);

	point_pair_t pending_pairs[$];
	logic [25:0] expected_dist[$];
	logic [15:0] radius_km = RADIUS_RESET;
	int errors = 0;
	int idle_cycles = 0;
	int cycle_no = 0;
	bit calm = 1'b0;
	logic full_q = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] deg_to_turns(longint deg);
		longint p;
		p = floor_shr(deg * longint'(TURN_MUL), ANGLE_FRAC_BITS + 8);
		return p[31:0];
	endfunction

	task automatic rotate_sin_cos(input logic [31:0] ang, output longint c, output longint s);
		logic flip;
		longint x, y, z, dx, dy;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		x = longint'(INV_GAIN);
		y = 0;
		if (flip) ang = ang + 32'h80000000;
		z = longint'(signed'(ang));
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		return floor_shr(a * b, 30);
	endfunction

	task automatic predict_distance(input point_pair_t pp, output logic [25:0] dist_out);
		logic [31:0] la1, lo1, la2, lo2, dla, dlo;
		longint c1, s1, c2, s2, cl, sl, co, so, a, x, y, z, dx, dy;
		longint unsigned w, d;
		la1 = deg_to_turns(longint'(signed'(pp.lat1)));
		lo1 = deg_to_turns(longint'(signed'(pp.lon1)));
		la2 = deg_to_turns(longint'(signed'(pp.lat2)));
		lo2 = deg_to_turns(longint'(signed'(pp.lon2)));
		dla = (la2 - la1) >> 1;
		dlo = (lo2 - lo1) >> 1;
		rotate_sin_cos(dla, cl, sl);
		rotate_sin_cos(dlo, co, so);
		rotate_sin_cos(la1, c1, s1);
		rotate_sin_cos(la2, c2, s2);
		a = mul_q30(sl, sl) + mul_q30(mul_q30(c1, c2), mul_q30(so, so));
		if (a < 0) a = 0;
		if (a > longint'(ONE_Q30)) a = longint'(ONE_Q30);
		y = root_floor(longint'(a) << 30);
		x = root_floor(longint'(longint'(ONE_Q30) - a) << 30);
		z = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end else begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(ONE_Q30)) z = longint'(ONE_Q30);
		w = (longint'(z) * longint'(PI_Q29) + (64'd1 << 28)) >> 29;
		d = (w * longint'(radius_km) + (64'd1 << 21)) >> 22;
		dist_out = (d > longint'(OUT_MAX)) ? OUT_MAX : d[25:0];
	endtask

	// 20 percent idling, except during the calm stretch
	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 20);
	endfunction

	// driver: present the head of the pending queue, advance on acceptance
	always @(negedge clk) begin
		logic [25:0] dist_exp;
		if (arst_n) begin
			if (push && !full_q) begin
				predict_distance(pending_pairs.pop_front(), dist_exp);
				expected_dist.push_back(dist_exp);
			end
			if (pending_pairs.size() > 0 && !take_break()) begin
				push <= 1'b1;
				{first_latitude, first_longitude, second_latitude, second_longitude}
					<= pending_pairs[0];
			end else begin
				push <= 1'b0;
			end
			pop <= !take_break();
		end
	end

	// sample full at the edge the transaction happens on
	always @(posedge clk) begin
		full_q <= full;
	end

	// monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no <= cycle_no + 1;
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (pop && !empty) begin
				if (expected_dist.size() == 0) begin
					$display("%0t: unexpected result %0d", $realtime, great_circle_distance);
					errors <= errors + 1;
				end else if (expected_dist[0] !== great_circle_distance) begin
					$display("%0t: distance expected %0d actual %0d", $realtime,
						expected_dist[0], great_circle_distance);
					errors <= errors + 1;
					void'(expected_dist.pop_front());
				end else begin
					void'(expected_dist.pop_front());
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[haversine_distance_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic write_radius(input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(REG_RADIUS) << 2; pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		radius_km = value;
	endtask

	task automatic drain();
		while (pending_pairs.size() > 0 || expected_dist.size() > 0 || push)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic point_pair_t make_pair(longint a, longint b, longint c, longint d);
		point_pair_t pp;
		pp.lat1 = a[27:0]; pp.lon1 = b[28:0]; pp.lat2 = c[27:0]; pp.lon2 = d[28:0];
		return pp;
	endfunction

	function automatic longint rand_in(longint lim);
		return longint'($urandom_range(32'(2 * lim))) - lim;
	endfunction

	// random pair; mostly in range, sometimes raw bit patterns, sometimes near each other
	function automatic point_pair_t random_pair();
		point_pair_t pp;
		int kind;
		longint la, lo;
		kind = $urandom_range(9);
		if (kind < 2) begin
			pp = PP_W'({$urandom, $urandom, $urandom, $urandom});
		end else if (kind < 4) begin
			la = rand_in(94371840);
			lo = rand_in(188743680);
			pp = make_pair(la, lo, la + rand_in(1 << $urandom_range(20)),
				lo + rand_in(1 << $urandom_range(22)));
		end else begin
			pp = make_pair(rand_in(94371840), rand_in(188743680),
				rand_in(94371840), rand_in(188743680));
		end
		return pp;
	endfunction

	initial begin
		logic [15:0] radii[5];
		radii = '{16'd1, 16'd65535, 16'd6371, 16'd0, 16'd1737};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: poles, antipodes, extremes, identical points, raw bit patterns
		pending_pairs.push_back(make_pair(0, 0, 0, 0));
		pending_pairs.push_back(make_pair(94371840, 0, -94371840, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 188743680));
		pending_pairs.push_back(make_pair(0, -188743680, 0, 188743680));
		pending_pairs.push_back(make_pair(-94371840, -188743680, 94371840, 188743680));
		pending_pairs.push_back(make_pair(0, 0, 0, 94371840));
		pending_pairs.push_back(make_pair(47185920, 10, 47185920, 11));
		pending_pairs.push_back(make_pair(1, 1, -1, -1));
		pending_pairs.push_back({28'h7FFFFFF, 29'h0FFFFFFF, 28'h8000000, 29'h10000000});
		pending_pairs.push_back({28'h8000000, 29'h10000000, 28'h7FFFFFF, 29'h0FFFFFFF});
		pending_pairs.push_back({28'hFFFFFFF, 29'h1FFFFFFF, 28'h0, 29'h0});
		pending_pairs.push_back(make_pair(30000000, 50000000, -30000000, -130000000));
		drain();

		// sweep radius extremes and middles, including zero and the largest radius
		foreach (radii[r]) begin
			write_radius(radii[r]);
			pending_pairs.push_back(make_pair(94371840, 0, -94371840, 0));
			pending_pairs.push_back(make_pair(0, 0, 0, 188743680));
			for (int k = 0; k < 266; k++) begin
				pending_pairs.push_back(random_pair());
			end
			calm = (r == 2);
			drain();
			calm = 1'b0;
		end

		if (errors == 0) begin
			$display("[haversine_distance_unit] OK");
		end else begin
			$display("[haversine_distance_unit] ERROR");
		end
		$finish;
	end
endmodule
